>>> hdl/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_DELETE  = 3'd1;
	localparam logic [2:0] OP_SEARCH  = 3'd2;
	localparam logic [2:0] OP_REPLACE = 3'd3;
	localparam logic [2:0] OP_READ    = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_PRESENT   = 3'd4;
	localparam logic [2:0] ST_BAD_POS   = 3'd5;

	// one element of the scan chain that walks toward cell 0
	typedef struct packed {
		logic        lt;
		logic        eq;
		logic [31:0] data;
	} scan_word_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;
		logic shift;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

>>> hdl/skt_cell.sv
// One table slot: entry register, compare flag and scan chain stage.
module skt_cell (
	input  logic                clk,
	input  skt_pkg::cell_ctl_t  ctl,
	input  logic signed [31:0]  operand,
	input  logic                occupied,
	input  logic [31:0]         lo_entry,
	input  logic                lo_lt,
	input  logic [31:0]         hi_entry,
	input  skt_pkg::scan_word_t hi_scan,
	output logic [31:0]         entry,
	output logic                lt,
	output skt_pkg::scan_word_t scan
);

	logic [31:0]         entry_q;
	logic                lt_q;
	skt_pkg::scan_word_t scan_q;
	logic                lt_c;
	logic                eq_c;

	assign lt_c = occupied && ($signed(entry_q) < operand);
	assign eq_c = occupied && (entry_q == operand);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lt_q   <= lt_c;
			scan_q <= '{lt: lt_c, eq: eq_c, data: entry_q};
		end else if (ctl.shift) begin
			scan_q <= hi_scan;
		end
		// slots below the target hold; on insert the target takes the key and the rest move up, on delete they move down
		if (ctl.ins && !lt_q) begin
			entry_q <= lo_lt ? operand : lo_entry;
		end
		if (ctl.del && !lt_q) begin
			entry_q <= hi_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign scan  = scan_q;

endmodule

>>> hdl/sorted_key_table.sv
// Sorted key table: top level with the operation sequencer and the row of cells.
//
// Input words (opcode, key, new_key, position_in) arrive on in_valid/in_ready;
// one result word (status, position_out, value, entry_count) leaves on
// out_valid/out_ready for every accepted input word.
// The keys live in a row of CAPACITY cells, one key each, in ascending order.
// A compare step flags every cell whose key is below the operand; a scan
// chain then shifts those flags toward cell 0, one slot per cycle, to count
// the slots below the operand, or for a read to reach the asked position.
// Insert and delete move the entries from the target up at once, each cell
// taking its neighbor's key.
// Early failures and unused opcodes go straight to the result; search runs a
// compare and a scan, insert and delete add an apply step, read scans to
// position_in, and replace runs two scans plus delete and insert passes.
// One word is worked on at a time: in_ready is high while the sequencer idles,
// so no new word is taken until the last result is in the output register.
// The result sits in an output register; a stalled receiver holds the next
// result back and the block waits for it after finishing its work.
// Reset empties the table (count zero); entry contents are not cleared.
module sorted_key_table #(
	parameter int CAPACITY = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic signed [31:0] key,
	input  logic signed [31:0] new_key,
	input  logic [3:0]         position_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [3:0]         position_out,
	output logic signed [31:0] value,
	output logic [3:0]         entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	localparam logic [1:0] PH_FIND_OLD = 2'd0;
	localparam logic [1:0] PH_FIND_NEW = 2'd1;
	localparam logic [1:0] PH_DEL      = 2'd2;
	localparam logic [1:0] PH_INS      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SCAN,
		S_APPLY,
		S_FINISH
	} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic signed [31:0] key_q;
	logic signed [31:0] nkey_q;
	logic [3:0]         pin_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      scan_q;
	logic [CW-1:0]      slot_s_q;
	logic [1:0]         phase_q;
	logic               use_new_q;
	logic [2:0]         res_status_q;
	logic [PW-1:0]      res_pos_q;
	logic [31:0]        res_value_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [PW-1:0]      pos_q;
	logic [31:0]        value_q;
	logic [PW-1:0]      count_q;

	logic signed [31:0]  operand;
	skt_pkg::cell_ctl_t  ctl;
	logic                apply_ins;
	logic                shift_go;
	skt_pkg::scan_word_t head;
	logic [PW-1:0]       p_ext;
	logic [PW-1:0]       p_inc;
	logic                early_fail;
	logic [2:0]          early_status;
	logic                res_load;

	logic [31:0]         entry_w [CAPACITY];
	logic                lt_w    [CAPACITY];
	skt_pkg::scan_word_t scan_w  [CAPACITY];

	assign operand   = use_new_q ? nkey_q : key_q;
	assign apply_ins = (op_q == skt_pkg::OP_INSERT) || (phase_q == PH_INS);
	assign head      = scan_w[0];
	assign p_ext     = PW'(scan_q);
	assign p_inc     = p_ext + PW'(1);
	assign res_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		if (op_q == skt_pkg::OP_READ) begin
			shift_go = (p_ext != (PW'(pin_q) - PW'(1)));
		end else begin
			shift_go = head.lt;
		end
	end

	// checks that need no scan
	always_comb begin
		early_fail   = 1'b0;
		early_status = skt_pkg::ST_OK;
		case (opcode)
			skt_pkg::OP_INSERT: begin
				if (cnt_q == CW'(CAPACITY)) begin
					early_fail   = 1'b1;
					early_status = skt_pkg::ST_FULL;
				end
			end
			skt_pkg::OP_DELETE, skt_pkg::OP_REPLACE: begin
				if (cnt_q == '0) begin
					early_fail   = 1'b1;
					early_status = skt_pkg::ST_EMPTY;
				end
			end
			skt_pkg::OP_SEARCH: begin
				early_fail = 1'b0;
			end
			skt_pkg::OP_READ: begin
				if (position_in == 4'd0 || PW'(position_in) > PW'(cnt_q)) begin
					early_fail   = 1'b1;
					early_status = skt_pkg::ST_BAD_POS;
				end
			end
			default: begin
				early_fail = 1'b1;
			end
		endcase
	end

	assign ctl.load  = (state_q == S_CMP);
	assign ctl.shift = (state_q == S_SCAN) && shift_go;
	assign ctl.ins   = (state_q == S_APPLY) && apply_ins;
	assign ctl.del   = (state_q == S_APPLY) && !apply_ins;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0]         lo_entry;
		logic                lo_lt;
		logic [31:0]         hi_entry;
		skt_pkg::scan_word_t hi_scan;

		if (i == 0) begin : g_first
			assign lo_entry = entry_w[i];
			assign lo_lt    = 1'b1;
		end else begin : g_lo
			assign lo_entry = entry_w[i-1];
			assign lo_lt    = lt_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign hi_entry = entry_w[i];
			assign hi_scan  = '0;
		end else begin : g_hi
			assign hi_entry = entry_w[i+1];
			assign hi_scan  = scan_w[i+1];
		end

		skt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.operand  (operand),
			.occupied (CW'(i) < cnt_q),
			.lo_entry (lo_entry),
			.lo_lt    (lo_lt),
			.hi_entry (hi_entry),
			.hi_scan  (hi_scan),
			.entry    (entry_w[i]),
			.lt       (lt_w[i]),
			.scan     (scan_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= skt_pkg::OP_INSERT;
			key_q        <= '0;
			nkey_q       <= '0;
			pin_q        <= '0;
			cnt_q        <= '0;
			scan_q       <= '0;
			slot_s_q     <= '0;
			phase_q      <= PH_FIND_OLD;
			use_new_q    <= 1'b0;
			res_status_q <= skt_pkg::ST_OK;
			res_pos_q    <= '0;
			res_value_q  <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= skt_pkg::ST_OK;
			pos_q        <= '0;
			value_q      <= '0;
			count_q      <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= opcode;
						key_q        <= key;
						nkey_q       <= new_key;
						pin_q        <= position_in;
						phase_q      <= PH_FIND_OLD;
						use_new_q    <= 1'b0;
						res_status_q <= early_status;
						res_pos_q    <= '0;
						res_value_q  <= '0;
						state_q      <= early_fail ? S_FINISH : S_CMP;
					end
				end
				S_CMP: begin
					scan_q <= '0;
					// replace passes after both checks go straight to the move
					if (phase_q == PH_DEL || phase_q == PH_INS) begin
						state_q <= S_APPLY;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (shift_go) begin
						scan_q <= scan_q + CW'(1);
					end else begin
						case (op_q)
							skt_pkg::OP_READ: begin
								res_value_q <= head.data;
								res_pos_q   <= PW'(pin_q);
								state_q     <= S_FINISH;
							end
							skt_pkg::OP_INSERT: begin
								res_pos_q <= p_inc;
								if (head.eq) begin
									res_status_q <= skt_pkg::ST_PRESENT;
									state_q      <= S_FINISH;
								end else begin
									state_q <= S_APPLY;
								end
							end
							skt_pkg::OP_DELETE: begin
								if (head.eq) begin
									res_pos_q <= p_inc;
									state_q   <= S_APPLY;
								end else begin
									res_status_q <= skt_pkg::ST_NOT_FOUND;
									state_q      <= S_FINISH;
								end
							end
							skt_pkg::OP_SEARCH: begin
								if (head.eq) begin
									res_pos_q <= p_inc;
								end else begin
									res_status_q <= skt_pkg::ST_NOT_FOUND;
								end
								state_q <= S_FINISH;
							end
							skt_pkg::OP_REPLACE: begin
								if (phase_q == PH_FIND_OLD) begin
									if (!head.eq) begin
										res_status_q <= skt_pkg::ST_NOT_FOUND;
										state_q      <= S_FINISH;
									end else begin
										slot_s_q  <= scan_q;
										phase_q   <= PH_FIND_NEW;
										use_new_q <= 1'b1;
										state_q   <= S_CMP;
									end
								end else if (head.eq) begin
									res_status_q <= skt_pkg::ST_PRESENT;
									res_pos_q    <= p_inc;
									state_q      <= S_FINISH;
								end else begin
									// old key below the new slot frees one place under it
									res_pos_q <= (slot_s_q < scan_q) ? p_ext : p_inc;
									phase_q   <= PH_DEL;
									use_new_q <= 1'b0;
									state_q   <= S_CMP;
								end
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_APPLY: begin
					if (apply_ins) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
					if (phase_q == PH_DEL) begin
						phase_q   <= PH_INS;
						use_new_q <= 1'b1;
						state_q   <= S_CMP;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_load) begin
						status_q <= res_status_q;
						pos_q    <= res_pos_q;
						value_q  <= res_value_q;
						count_q  <= PW'(cnt_q);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign position_out = pos_q[3:0];
	assign value        = value_q;
	assign entry_count  = count_q[3:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && apply_ins) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not add one entry");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && !apply_ins) |=> cnt_q == $past(cnt_q) - CW'(1))
		else $error("delete did not remove one entry");

	a_no_move_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && !apply_ins) |-> cnt_q != '0)
		else $error("delete on an empty table");

endmodule
